>>> rtl/core/izn_pkg.sv
package izn_pkg;

    // Field widths
    localparam int C_W      = 32;
    localparam int C_IDX_W  = 3;
    localparam int C_MA_W   = 35;
    localparam int C_MB_W   = 33;
    localparam int C_P_W    = C_MA_W + C_MB_W;
    localparam int C_Q32_W  = C_P_W - 32;

    localparam int C_FRAC_BITS = 16;

    // Step constants as positive Q0.32 in a signed 33-bit field: dt/cm and dt
    localparam logic signed [C_MB_W-1:0] C_DT_OVER_CM = 33'sd373475;
    localparam logic signed [C_MB_W-1:0] C_DT         = 33'sd42949673;

    // Register reset values
    localparam logic signed [C_W-1:0] C_RST_RATE  = 32'sd0;
    localparam logic signed [C_W-1:0] C_RST_GAIN  = 32'sd0;
    localparam logic signed [C_W-1:0] C_RST_JUMP  = 32'sd0;
    localparam logic signed [C_W-1:0] C_RST_KLO   = 32'sd0;
    localparam logic signed [C_W-1:0] C_RST_KHI   = 32'sd216269;
    localparam logic signed [C_W-1:0] C_RST_REST  = -32'sd4050125;
    localparam logic signed [C_W-1:0] C_RST_THR   = -32'sd3735552;
    localparam logic signed [C_W-1:0] C_RST_PEAK  = 32'sd1481114;

    typedef enum logic [C_IDX_W-1:0] {
        CFG_RATE  = 3'd0,
        CFG_GAIN  = 3'd1,
        CFG_JUMP  = 3'd2,
        CFG_KLO   = 3'd3,
        CFG_KHI   = 3'd4,
        CFG_REST  = 3'd5,
        CFG_THR   = 3'd6,
        CFG_PEAK  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [C_W-1:0] rate;
        logic signed [C_W-1:0] gain;
        logic signed [C_W-1:0] jump;
        logic signed [C_W-1:0] k_lo;
        logic signed [C_W-1:0] k_hi;
        logic signed [C_W-1:0] rest;
        logic signed [C_W-1:0] thr;
        logic signed [C_W-1:0] peak;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_QUAD,
        S_KQ,
        S_VN,
        S_VD,
        S_BR,
        S_SA,
        S_UN,
        S_FIN
    } t_state;

    // Clamp to the signed 32-bit range
    function automatic logic signed [C_W-1:0] f_sat32(input logic signed [63:0] x);
        logic signed [C_W-1:0] y;
        if (x > 64'sd2147483647) begin
            y = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[C_W-1:0];
        end
        return y;
    endfunction

endpackage

>>> rtl/core/spiking_neuron_euler_step.sv
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_drive_current
// output    out        o_out_valid / i_out_stall    o_membrane_v, o_recovery_u, o_spiked
// config    in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// One tick makes six passes through one shared 35x33 multiplier (operands registered,
// then the product registered), a voltage update, a recovery update and the finish
// step; a new tick transfers only once the previous one has left the finish step.
// A new tick is taken while the previous result waits in the output register;
// the finish step holds until that register is free.
// Synchronous active-low reset restores control and config registers, v = -60 mV and u = 0.
module spiking_neuron_euler_step #(
    parameter int FRAC_BITS = izn_pkg::C_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [izn_pkg::C_W-1:0] i_drive_current,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [izn_pkg::C_W-1:0] o_membrane_v,
    output logic signed [izn_pkg::C_W-1:0] o_recovery_u,
    output logic                           o_spiked,
    input  logic                           i_cfg_we,
    input  logic [izn_pkg::C_IDX_W-1:0]    i_cfg_index,
    input  logic [izn_pkg::C_W-1:0]        i_cfg_data
);
    import izn_pkg::*;

    localparam logic signed [63:0] START_V64 = -64'sd60 * (64'sd1 <<< FRAC_BITS);
    localparam logic signed [63:0] RESET_V64 = (-64'sd658 * (64'sd1 <<< FRAC_BITS) - 64'sd5)
                                               / 64'sd10;
    localparam logic signed [C_W-1:0] START_V = START_V64[C_W-1:0];
    localparam logic signed [C_W-1:0] RESET_V = RESET_V64[C_W-1:0];

    t_cfg w_cfg;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    logic signed [C_W-1:0]    r_v, n_v;
    logic signed [C_W-1:0]    r_u, n_u;
    logic signed [C_W-1:0]    r_cur, n_cur;
    logic signed [C_W-1:0]    r_vn, n_vn;
    logic signed [C_W-1:0]    r_un, n_un;
    logic signed [C_MA_W-1:0] r_op_a, n_op_a;
    logic signed [C_MB_W-1:0] r_op_b, n_op_b;

    logic signed [C_W-1:0] r_out_v, n_out_v;
    logic signed [C_W-1:0] r_out_u, n_out_u;
    logic                  r_out_spk, n_out_spk;
    logic                  r_out_valid, n_out_valid;

    logic signed [C_W-1:0]     w_frac;
    logic signed [C_Q32_W-1:0] w_q32;
    logic                      w_out_free;

    izn_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    izn_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_load (r_state == S_MUL),
        .i_op_a (r_op_a),
        .i_op_b (r_op_b),
        .o_frac (w_frac),
        .o_q32  (w_q32)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequence one Euler step through the shared multiplier
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_v         = r_v;
        n_u         = r_u;
        n_cur       = r_cur;
        n_vn        = r_vn;
        n_un        = r_un;
        n_op_a      = r_op_a;
        n_op_b      = r_op_b;
        n_out_v     = r_out_v;
        n_out_u     = r_out_u;
        n_out_spk   = r_out_spk;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cur   = i_drive_current;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_op_a  = C_MA_W'(f_sat32(64'(r_v) - 64'(w_cfg.rest)));
                n_op_b  = C_MB_W'(f_sat32(64'(r_v) - 64'(w_cfg.thr)));
                n_ret   = S_QUAD;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = r_ret;
            end
            S_QUAD: begin
                n_op_a  = (r_v <= w_cfg.thr) ? C_MA_W'(w_cfg.k_lo) : C_MA_W'(w_cfg.k_hi);
                n_op_b  = C_MB_W'(w_frac);
                n_ret   = S_KQ;
                n_state = S_MUL;
            end
            S_KQ: begin
                // hold the sum exactly before scaling by dt/cm
                n_op_a  = C_MA_W'(w_frac) - C_MA_W'(r_u) + C_MA_W'(r_cur);
                n_op_b  = C_DT_OVER_CM;
                n_ret   = S_VN;
                n_state = S_MUL;
            end
            S_VN: begin
                n_vn    = f_sat32(64'(r_v) + 64'(w_q32));
                n_state = S_VD;
            end
            S_VD: begin
                n_op_a  = C_MA_W'(w_cfg.gain);
                n_op_b  = C_MB_W'(f_sat32(64'(r_vn) - 64'(w_cfg.rest)));
                n_ret   = S_BR;
                n_state = S_MUL;
            end
            S_BR: begin
                n_op_a  = C_MA_W'(w_cfg.rate);
                n_op_b  = C_MB_W'(f_sat32(64'(w_frac) - 64'(r_u)));
                n_ret   = S_SA;
                n_state = S_MUL;
            end
            S_SA: begin
                n_op_a  = C_MA_W'(w_frac);
                n_op_b  = C_DT;
                n_ret   = S_UN;
                n_state = S_MUL;
            end
            S_UN: begin
                n_un    = f_sat32(64'(r_u) + 64'(w_q32));
                n_state = S_FIN;
            end
            S_FIN: begin
                // wait until the output register can take the result
                if (w_out_free) begin
                    if (r_vn >= w_cfg.peak) begin
                        n_v       = RESET_V;
                        n_u       = f_sat32(64'(r_un) + 64'(w_cfg.jump));
                        n_out_spk = 1'b1;
                    end else begin
                        n_v       = r_vn;
                        n_u       = r_un;
                        n_out_spk = 1'b0;
                    end
                    n_out_v     = n_v;
                    n_out_u     = n_u;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and neuron state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_v         <= START_V;
            r_u         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_v         <= n_v;
            r_u         <= n_u;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath holding registers
    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_vn      <= n_vn;
        r_un      <= n_un;
        r_op_a    <= n_op_a;
        r_op_b    <= n_op_b;
        r_out_v   <= n_out_v;
        r_out_u   <= n_out_u;
        r_out_spk <= n_out_spk;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_membrane_v = r_out_v;
    assign o_recovery_u = r_out_u;
    assign o_spiked     = r_out_spk;

    // A new result only appears from the finish step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result appeared outside the finish step");

    // A spike always leaves the voltage at the reset level
    a_spike_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_spk |-> r_out_v == RESET_V && r_v == RESET_V)
        else $error("spike without voltage reset");

    // A multiply pass always returns to a post-processing step
    a_mul_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> (r_ret == S_QUAD || r_ret == S_KQ || r_ret == S_VN ||
                              r_ret == S_BR || r_ret == S_SA || r_ret == S_UN))
        else $error("multiply pass with bad return step");

    // The finish step never overwrites a result that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && r_out_valid && i_out_stall |=> r_state == S_FIN && r_out_valid)
        else $error("held result overwritten");

endmodule

>>> rtl/core/izn_cfg.sv
module izn_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [izn_pkg::C_IDX_W-1:0]   i_cfg_index,
    input  logic [izn_pkg::C_W-1:0]       i_cfg_data,
    output izn_pkg::t_cfg                 o_cfg
);
    import izn_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RATE: n_cfg.rate = $signed(i_cfg_data);
                CFG_GAIN: n_cfg.gain = $signed(i_cfg_data);
                CFG_JUMP: n_cfg.jump = $signed(i_cfg_data);
                CFG_KLO:  n_cfg.k_lo = $signed(i_cfg_data);
                CFG_KHI:  n_cfg.k_hi = $signed(i_cfg_data);
                CFG_REST: n_cfg.rest = $signed(i_cfg_data);
                CFG_THR:  n_cfg.thr  = $signed(i_cfg_data);
                CFG_PEAK: n_cfg.peak = $signed(i_cfg_data);
                default:  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate <= C_RST_RATE;
            r_cfg.gain <= C_RST_GAIN;
            r_cfg.jump <= C_RST_JUMP;
            r_cfg.k_lo <= C_RST_KLO;
            r_cfg.k_hi <= C_RST_KHI;
            r_cfg.rest <= C_RST_REST;
            r_cfg.thr  <= C_RST_THR;
            r_cfg.peak <= C_RST_PEAK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/izn_mac.sv
module izn_mac #(
    parameter int FRAC_BITS = izn_pkg::C_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic signed [izn_pkg::C_MA_W-1:0]    i_op_a,
    input  logic signed [izn_pkg::C_MB_W-1:0]    i_op_b,
    output logic signed [izn_pkg::C_W-1:0]       o_frac,
    output logic signed [izn_pkg::C_Q32_W-1:0]   o_q32
);
    import izn_pkg::*;

    localparam logic signed [C_P_W-1:0] HALF_F   = C_P_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [C_P_W-1:0] HALF_Q32 = C_P_W'(64'sd1 <<< 31);

    logic signed [C_P_W-1:0] r_prod;
    logic signed [C_P_W-1:0] w_rnd_f;
    logic signed [C_P_W-1:0] w_shf_f;
    logic signed [C_P_W-1:0] w_rnd_q;
    logic signed [C_P_W-1:0] w_shf_q;

    // Multiply the held operands
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= i_op_a * i_op_b;
        end
    end

    // Round half up, then clamp for the fraction-scaled product
    assign w_rnd_f = r_prod + HALF_F;
    assign w_shf_f = w_rnd_f >>> FRAC_BITS;
    assign o_frac  = f_sat32($signed(w_shf_f[63:0]));

    // Round half up for the Q0.32 step constants, left unclamped
    assign w_rnd_q = r_prod + HALF_Q32;
    assign w_shf_q = w_rnd_q >>> 32;
    assign o_q32   = $signed(w_shf_q[C_Q32_W-1:0]);

endmodule

>>> bench/izn_tick_checker.sv
module izn_tick_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic signed [izn_pkg::C_W-1:0] i_drive_current,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic signed [izn_pkg::C_W-1:0] i_membrane_v,
    input  logic signed [izn_pkg::C_W-1:0] i_recovery_u,
    input  logic                           i_spiked,
    input  logic                           i_cfg_we,
    input  logic [izn_pkg::C_IDX_W-1:0]    i_cfg_index,
    input  logic [izn_pkg::C_W-1:0]        i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import izn_pkg::*;

    localparam int     NUM_REGS   = 2 ** C_IDX_W;
    localparam int     FRAC       = C_FRAC_BITS;
    localparam longint STEP_SCALE = 64'sd373475;    // dt/cm in Q0.32
    localparam longint DT_SCALE   = 64'sd42949673;  // dt in Q0.32
    localparam longint START_MV   = -64'sd60 * (64'sd1 <<< FRAC);
    localparam longint SPIKE_MV   = (-64'sd658 * (64'sd1 <<< FRAC) - 64'sd5) / 64'sd10;
    localparam longint MAX32      = 64'sd2147483647;
    localparam longint MIN32      = -64'sd2147483648;

    typedef struct packed {
        logic signed [C_W-1:0] v;
        logic signed [C_W-1:0] u;
        logic                  spk;
    } t_tick_result;

    longint       cfg_q [NUM_REGS];
    longint       v_now;
    longint       u_now;
    t_tick_result predicted_ticks [$];
    int           errs = 0;
    int           pending_n = 0;

    assign o_fail_count = errs;
    assign o_pending    = pending_n;

    function automatic longint clamp32(input longint x);
        if (x > MAX32) return MAX32;
        if (x < MIN32) return MIN32;
        return x;
    endfunction

    // Round half up: floor(x / 2^s + 1/2)
    function automatic longint rnd_shift(input longint x, input int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint fxmul(input longint p, input longint q);
        return clamp32(rnd_shift(p * q, FRAC));
    endfunction

    // Advance the neuron by one Euler tick and return what it should report
    function automatic t_tick_result step_neuron(input logic signed [C_W-1:0] cur_in);
        longint       k, dv_rest, dv_thr, quad, drive, vn, br, un;
        t_tick_result r;
        k       = (v_now <= cfg_q[CFG_THR]) ? cfg_q[CFG_KLO] : cfg_q[CFG_KHI];
        dv_rest = clamp32(v_now - cfg_q[CFG_REST]);
        dv_thr  = clamp32(v_now - cfg_q[CFG_THR]);
        quad    = fxmul(dv_rest, dv_thr);
        drive   = fxmul(k, quad) - u_now + longint'(cur_in);
        vn      = clamp32(v_now + rnd_shift(drive * STEP_SCALE, 32));
        // recovery update uses the new voltage
        br      = fxmul(cfg_q[CFG_GAIN], clamp32(vn - cfg_q[CFG_REST]));
        br      = clamp32(br - u_now);
        br      = fxmul(cfg_q[CFG_RATE], br);
        un      = clamp32(u_now + rnd_shift(br * DT_SCALE, 32));
        r.spk   = 1'b0;
        if (vn >= cfg_q[CFG_PEAK]) begin
            vn    = SPIKE_MV;
            un    = clamp32(un + cfg_q[CFG_JUMP]);
            r.spk = 1'b1;
        end
        v_now = vn;
        u_now = un;
        r.v   = vn[C_W-1:0];
        r.u   = un[C_W-1:0];
        return r;
    endfunction

    // Watch every transfer: retire results, predict new ticks, track register writes
    always @(posedge i_clk) begin : watch
        t_tick_result exp_r;
        if (!i_rst_n) begin
            cfg_q[CFG_RATE] = 0;
            cfg_q[CFG_GAIN] = 0;
            cfg_q[CFG_JUMP] = 0;
            cfg_q[CFG_KLO]  = 0;
            cfg_q[CFG_KHI]  = 216269;
            cfg_q[CFG_REST] = -4050125;
            cfg_q[CFG_THR]  = -3735552;
            cfg_q[CFG_PEAK] = 1481114;
            v_now = START_MV;
            u_now = 0;
            predicted_ticks.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_ticks.size() == 0) begin
                    $error("result with none expected: membrane_v %0d recovery_u %0d spiked %0b",
                           i_membrane_v, i_recovery_u, i_spiked);
                    errs++;
                end else begin
                    exp_r = predicted_ticks.pop_front();
                    if (i_membrane_v !== exp_r.v) begin
                        $error("membrane_v: expected %0d, got %0d", exp_r.v, i_membrane_v);
                        errs++;
                    end
                    if (i_recovery_u !== exp_r.u) begin
                        $error("recovery_u: expected %0d, got %0d", exp_r.u, i_recovery_u);
                        errs++;
                    end
                    if (i_spiked !== exp_r.spk) begin
                        $error("spiked: expected %0b, got %0b", exp_r.spk, i_spiked);
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predicted_ticks.push_back(step_neuron(i_drive_current));
            end
            if (i_cfg_we) begin
                cfg_q[i_cfg_index] = longint'($signed(i_cfg_data));
            end
        end
        pending_n = predicted_ticks.size();
    end

endmodule

>>> bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import izn_pkg::*;

    localparam int NUM_REGS    = 2 ** C_IDX_W;
    localparam int IDLE_PCT    = 9;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCH_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    localparam logic [C_W-1:0] MAX_VAL  = 32'h7FFFFFFF;
    localparam logic [C_W-1:0] MIN_VAL  = 32'h80000000;
    localparam logic [C_W-1:0] START_MV = -32'sd3932160;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic signed [C_W-1:0] i_drive_current = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic signed [C_W-1:0] o_membrane_v;
    logic signed [C_W-1:0] o_recovery_u;
    logic                  o_spiked;
    logic                  i_cfg_we        = 1'b0;
    logic [C_IDX_W-1:0]    i_cfg_index     = '0;
    logic [C_W-1:0]        i_cfg_data      = '0;

    int fail_count;
    int pending_n;

    // Shared between the sender and the receiver
    logic quiet_run = 1'b0;
    logic hold_req  = 1'b0;

    // Register values waiting to be written
    logic [C_W-1:0]      reg_plan [NUM_REGS];
    logic [NUM_REGS-1:0] plan_mask = '0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    spiking_neuron_euler_step dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_drive_current (i_drive_current),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_membrane_v    (o_membrane_v),
        .o_recovery_u    (o_recovery_u),
        .o_spiked        (o_spiked),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    izn_tick_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_drive_current (i_drive_current),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_membrane_v    (o_membrane_v),
        .i_recovery_u    (o_recovery_u),
        .i_spiked        (o_spiked),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_n)
    );

    // Receiver: random stalls, a quiet stretch, and one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
                if (hold_left == 0) hold_req = 1'b0;
            end else if (hold_req) begin
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (quiet_run) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Abort when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCH_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    function automatic logic [C_W-1:0] rand_reg();
        if ($urandom_range(1) == 0) return $urandom;
        return C_W'($urandom_range(0, 2097152)) - 32'd1048576;
    endfunction

    function automatic logic [C_W-1:0] rand_edge_value();
        case ($urandom_range(4))
            0: return MAX_VAL;
            1: return MIN_VAL;
            2: return '0;
            3: return 32'd1;
            default: return '1;
        endcase
    endfunction

    task automatic set_reg(input t_cfg_idx idx, input logic [C_W-1:0] val);
        reg_plan[idx]  = val;
        plan_mask[idx] = 1'b1;
    endtask

    task automatic set_all_regs(input logic [C_W-1:0] val);
        int i;
        for (i = 0; i < NUM_REGS; i++) set_reg(t_cfg_idx'(i), val);
    endtask

    // Write the planned registers, one per cycle
    task automatic apply_plan();
        int   i;
        logic any;
        any = 1'b0;
        for (i = 0; i < NUM_REGS; i++) begin
            if (plan_mask[i]) begin
                i_cfg_we    <= 1'b1;
                i_cfg_index <= t_cfg_idx'(i);
                i_cfg_data  <= reg_plan[i];
                @(posedge i_clk);
                any = 1'b1;
            end
        end
        if (any) i_cfg_we <= 1'b0;
        plan_mask = '0;
    endtask

    // Offer one tick, with random gaps ahead of it, and hold it until transfer
    task automatic send_tick(input logic [C_W-1:0] cur);
        while (!quiet_run && ($urandom_range(99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_drive_current <= cur;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_n != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Mostly current steps held for a while (to drive spikes), the rest noise
    task automatic run_ticks(input int count);
        int             sent_n;
        int             run_left;
        logic           train;
        logic [C_W-1:0] level;
        logic [C_W-1:0] cur;
        sent_n   = 0;
        run_left = 0;
        train    = 1'b0;
        level    = '0;
        while (sent_n < count) begin
            if (run_left == 0) begin
                train = ($urandom_range(99) < 70);
                if (train) begin
                    run_left = $urandom_range(5, 60);
                    level = (C_W'($urandom_range(12000, 32767)) << 16) | ($urandom & 32'hFFFF);
                    if ($urandom_range(3) == 0) level = -level;
                end else begin
                    run_left = $urandom_range(1, 8);
                end
            end
            if (train) begin
                cur = level + (C_W'($urandom_range(0, 262144)) - 32'd131072);
            end else if ($urandom_range(3) == 0) begin
                cur = rand_edge_value();
            end else begin
                cur = $urandom;
            end
            send_tick(cur);
            run_left--;
            sent_n++;
        end
    endtask

    initial begin : stimulus
        int i;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, with voltage starting exactly at threshold
        set_reg(CFG_THR, START_MV);
        apply_plan();
        send_tick('0);
        send_tick('0);
        send_tick(32'd1);
        send_tick('1);
        send_tick(MAX_VAL);
        send_tick(MIN_VAL);
        drain();

        // Low peak so a few strong ticks fire a spike
        set_reg(CFG_RATE, 32'sd1966);
        set_reg(CFG_GAIN, -32'sd131072);
        set_reg(CFG_JUMP, 32'sd6553600);
        set_reg(CFG_KLO,  32'sd216269);
        set_reg(CFG_KHI,  32'sd45875);
        set_reg(CFG_REST, -32'sd4050125);
        set_reg(CFG_THR,  START_MV);
        set_reg(CFG_PEAK, -32'sd3276800);
        apply_plan();
        repeat (8) send_tick(MAX_VAL);
        repeat (3) send_tick(MIN_VAL);
        send_tick(32'h55555555);
        send_tick(32'hAAAAAAAA);
        send_tick('0);
        drain();

        // Typical neuron; receiver holds off long enough to back up the input
        set_reg(CFG_RATE, 32'sd1966);
        set_reg(CFG_GAIN, 32'sd327680);
        set_reg(CFG_JUMP, 32'sd6553600);
        set_reg(CFG_KLO,  32'sd45875);
        set_reg(CFG_KHI,  32'sd98304);
        set_reg(CFG_REST, START_MV);
        set_reg(CFG_THR,  -32'sd2621440);
        set_reg(CFG_PEAK, 32'sd2293760);
        apply_plan();
        hold_req = 1'b1;
        run_ticks(200);
        drain();

        // Frequent spikes, no idling on either side
        set_reg(CFG_JUMP, -32'sd32768000);
        set_reg(CFG_KLO,  32'sd1310720);
        set_reg(CFG_KHI,  32'sd1310720);
        set_reg(CFG_THR,  -32'sd3604480);
        set_reg(CFG_PEAK, -32'sd2949120);
        apply_plan();
        quiet_run = 1'b1;
        run_ticks(200);
        drain();
        quiet_run = 1'b0;

        // Register extremes drive every step into saturation
        set_all_regs(MAX_VAL);
        apply_plan();
        run_ticks(60);
        drain();
        set_all_regs(MIN_VAL);
        apply_plan();
        run_ticks(60);
        drain();

        // Random register settings
        for (i = 0; i < 3; i++) begin
            set_reg(CFG_RATE, rand_reg());
            set_reg(CFG_GAIN, rand_reg());
            set_reg(CFG_JUMP, rand_reg());
            set_reg(CFG_KLO,  rand_reg());
            set_reg(CFG_KHI,  rand_reg());
            set_reg(CFG_REST, rand_reg());
            set_reg(CFG_THR,  rand_reg());
            set_reg(CFG_PEAK, rand_reg());
            apply_plan();
            run_ticks(40);
            drain();
        end

        // Fast recovery so u moves a lot between spikes
        set_reg(CFG_RATE, 32'sd65536);
        set_reg(CFG_GAIN, 32'sd13107);
        set_reg(CFG_JUMP, -32'sd524288);
        set_reg(CFG_KLO,  32'sd45875);
        set_reg(CFG_KHI,  32'sd216269);
        set_reg(CFG_REST, -32'sd4050125);
        set_reg(CFG_THR,  -32'sd3735552);
        set_reg(CFG_PEAK, 32'sd1481114);
        apply_plan();
        run_ticks(190);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_n != 0) $error("%0d expected results never arrived", pending_n);
        if (fail_count == 0 && pending_n == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
